### hw/rtl/ptau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptau_pkg;

   localparam int SLOT_MAX     = 8;
   localparam int NUM_TASKS_DEF = 8;
   localparam int CYCLE_W      = 30;
   localparam int TIME_W       = 32;
   localparam int LOSS_W       = 32;
   localparam int ACTION_W     = 2;
   localparam int TASK_ID_W    = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 60;

   localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK     = 2'd0,
      ACT_ACTIVATE = 2'd1,
      ACT_COMPLETE = 2'd2
   } action_type;

endpackage

`default_nettype wire

### hw/rtl/periodic_task_activation_unit.sv
// Channel   | Ports                                            | Beat
// ----------+--------------------------------------------------+------------------------------
// request   | start, busy, req_action, req_task_id             | start && !busy
// response  | rsp_valid, rsp_ready_mask, rsp_pending_mask,     | rsp_valid, one cycle, no stall
//           | rsp_activate_ok, rsp_loss_count                  |
// csr       | csr_valid, csr_ready, csr_index, csr_data        | csr_valid && csr_ready
//
// One beat per cycle; the response leaves registered behind the request beat
// (input register, then one pass over all slots into the result register).
// The per-slot due compare and due/loss adders set the combinational path between them.
// Synchronous reset clears time, pending bits, loss counters and timing; busy is high in reset.
// The receiver cannot stall; csr writes are taken at any time, intended only when idle.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_activation_unit #(
   parameter int NUM_TASKS = ptau_pkg::NUM_TASKS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire  [ptau_pkg::ACTION_W-1:0]         req_action,
   input  wire  [ptau_pkg::TASK_ID_W-1:0]        req_task_id,
   output logic                                  rsp_valid,
   output logic [ptau_pkg::SLOT_MAX-1:0]         rsp_ready_mask,
   output logic [ptau_pkg::SLOT_MAX-1:0]         rsp_pending_mask,
   output logic                                  rsp_activate_ok,
   output logic [ptau_pkg::LOSS_W-1:0]           rsp_loss_count,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [ptau_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [ptau_pkg::CSR_DATA_W-1:0]       csr_data
);
   import ptau_pkg::*;

   logic                    s1_valid_ff;
   action_type              s1_action_ff;
   logic [TASK_ID_W-1:0]    s1_id_ff;

   logic [TIME_W-1:0]       tick_ff, tick_in;
   logic [CYCLE_W-1:0]      cycle_ff [NUM_TASKS];
   logic [CYCLE_W-1:0]      cycle_in [NUM_TASKS];
   logic [TIME_W-1:0]       due_ff   [NUM_TASKS];
   logic [TIME_W-1:0]       due_in   [NUM_TASKS];
   logic [LOSS_W-1:0]       loss_ff  [NUM_TASKS];
   logic [LOSS_W-1:0]       loss_in  [NUM_TASKS];
   logic [NUM_TASKS-1:0]    pending_ff, pending_in;

   logic [NUM_TASKS-1:0]    ready_in;
   logic                    ok_in;
   logic [LOSS_W-1:0]       loss_sel_in;

   logic                    rsp_valid_ff;
   logic [SLOT_MAX-1:0]     rsp_ready_ff, rsp_pending_ff;
   logic                    rsp_ok_ff;
   logic [LOSS_W-1:0]       rsp_loss_ff;

   logic                    csr_wr;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      logic [TIME_W-1:0] diff_v;
      diff_v      = '0;
      tick_in     = tick_ff;
      pending_in  = pending_ff;
      ready_in    = '0;
      ok_in       = 1'b0;
      cycle_in    = cycle_ff;
      due_in      = due_ff;
      loss_in     = loss_ff;
      if (s1_valid_ff) begin
         case (s1_action_ff)
            ACT_TICK: begin
               for (int k = 0; k < NUM_TASKS; k++) begin
                  diff_v = due_ff[k] - tick_ff;
                  if ((cycle_ff[k] != '0) && ((diff_v == '0) || diff_v[TIME_W-1])) begin
                     if (!pending_ff[k]) begin
                        pending_in[k] = 1'b1;
                        ready_in[k]   = 1'b1;
                     end else if (loss_ff[k] != LOSS_MAX) begin
                        loss_in[k] = loss_ff[k] + 1'b1;
                     end
                     due_in[k] = due_ff[k] + TIME_W'(cycle_ff[k]);
                  end
               end
               tick_in = tick_ff + 1'b1;
            end
            ACT_ACTIVATE: begin
               for (int k = 0; k < NUM_TASKS; k++) begin
                  if (s1_id_ff == TASK_ID_W'(k)) begin
                     if (!pending_ff[k]) begin
                        pending_in[k] = 1'b1;
                        ready_in[k]   = 1'b1;
                        ok_in         = 1'b1;
                     end else if (loss_ff[k] != LOSS_MAX) begin
                        loss_in[k] = loss_ff[k] + 1'b1;
                     end
                  end
               end
            end
            ACT_COMPLETE: begin
               for (int k = 0; k < NUM_TASKS; k++) begin
                  if (s1_id_ff == TASK_ID_W'(k)) begin
                     pending_in[k] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_wr) begin
         for (int k = 0; k < NUM_TASKS; k++) begin
            if (csr_index == CSR_IDX_W'(k)) begin
               cycle_in[k] = csr_data[CYCLE_W-1:0];
               due_in[k]   = TIME_W'(csr_data[2*CYCLE_W-1:CYCLE_W]);
            end
         end
      end
   end

   always_comb begin
      loss_sel_in = LOSS_MAX;
      for (int k = 0; k < NUM_TASKS; k++) begin
         if (s1_id_ff == TASK_ID_W'(k)) begin
            loss_sel_in = loss_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         pending_ff   <= '0;
         for (int k = 0; k < NUM_TASKS; k++) begin
            cycle_ff[k] <= '0;
            due_ff[k]   <= '0;
            loss_ff[k]  <= '0;
         end
      end else begin
         s1_valid_ff  <= start && !busy;
         rsp_valid_ff <= s1_valid_ff;
         tick_ff      <= tick_in;
         pending_ff   <= pending_in;
         cycle_ff     <= cycle_in;
         due_ff       <= due_in;
         loss_ff      <= loss_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_action_ff   <= action_type'(req_action);
      s1_id_ff       <= req_task_id;
      rsp_ready_ff   <= SLOT_MAX'(ready_in);
      rsp_pending_ff <= SLOT_MAX'(pending_in);
      rsp_ok_ff      <= ok_in;
      rsp_loss_ff    <= loss_sel_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ready_mask   = rsp_ready_ff;
   assign rsp_pending_mask = rsp_pending_ff;
   assign rsp_activate_ok  = rsp_ok_ff;
   assign rsp_loss_count   = rsp_loss_ff;

endmodule

`default_nettype wire

### hw/rtl/ptau_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ptau_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                start,
   input wire                                busy,
   input wire                                rsp_valid,
   input wire [ptau_pkg::SLOT_MAX-1:0]       rsp_ready_mask,
   input wire [ptau_pkg::SLOT_MAX-1:0]       rsp_pending_mask,
   input wire                                rsp_activate_ok
);

   a_beat_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("request beat without response");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> ##1 !rsp_valid)
      else $error("response without request beat");

   a_ready_is_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_ready_mask & ~rsp_pending_mask) == '0))
      else $error("newly ready task not pending");

   a_ok_one_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_activate_ok) |-> ($countones(rsp_ready_mask) == 1))
      else $error("activation ok without single ready bit");

endmodule

bind periodic_task_activation_unit ptau_checker u_ptau_checker (.*);

`default_nettype wire
